/* rtl/core/cscr_pkg.sv */
package cscr_pkg;

  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned TBits   = 32;  // fraction bits of the projection parameter
  localparam int unsigned NBits   = 30;  // fraction bits of the normal
  localparam int unsigned RootW   = 31;  // bits of the integer square root
  localparam logic [RootW-1:0] NormOne = RootW'(1) << NBits;

  typedef enum logic [CfgIdxW-1:0] {
    REG_START_X = 8'd0,
    REG_START_Y = 8'd1,
    REG_END_X   = 8'd2,
    REG_END_Y   = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [30:0]        r;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
  } ball_t;

  // sideband through the projection divider
  typedef struct packed {
    ball_t              ball;
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic signed [32:0] wx;
    logic signed [32:0] wy;
    logic               degen;
    logic               t_zero;
    logic               t_one;
  } tside_t;

  // sideband through the square root
  typedef struct packed {
    ball_t              ball;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic               hit;
  } sside_t;

  // sideband through the normal dividers
  typedef struct packed {
    ball_t       ball;
    logic [30:0] dlen;
    logic        dx_neg;
    logic        dy_neg;
    logic        dzero;
    logic        ovf;
    logic        hit;
  } nside_t;

  typedef struct packed {
    ball_t              ball;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic [30:0]        dlen;
    logic               hit;
  } norm_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
  } result_t;

  // round v / 2^s to nearest, ties away from zero
  function automatic logic signed [65:0] rnd_shift(input logic signed [65:0] v,
                                                   input int unsigned s);
    logic [65:0] mag;
    logic [65:0] m;
    mag = v[65] ? 66'(-v) : 66'(v);
    m   = (mag + (66'd1 << (s - 1))) >> s;
    return v[65] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -66'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

/* rtl/core/cscr_if.sv */
interface cscr_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] ball_x;
  logic signed [31:0] ball_y;
  logic [30:0]        ball_radius;
  logic signed [31:0] ball_vel_x;
  logic signed [31:0] ball_vel_y;
  modport source(output valid, ball_x, ball_y, ball_radius, ball_vel_x, ball_vel_y,
                 input ready);
  modport sink(input valid, ball_x, ball_y, ball_radius, ball_vel_x, ball_vel_y,
               output ready);
endinterface

interface cscr_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] new_x;
  logic signed [31:0] new_y;
  logic signed [31:0] new_vel_x;
  logic signed [31:0] new_vel_y;
  modport source(output valid, hit, new_x, new_y, new_vel_x, new_vel_y, input ready);
  modport sink(input valid, hit, new_x, new_y, new_vel_x, new_vel_y, output ready);
endinterface

interface cscr_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* rtl/core/cscr_div_pipe.sv */
module cscr_div_pipe #(
  parameter int unsigned NUM_W  = 66,
  parameter int unsigned DEN_W  = 32,
  parameter int unsigned Q_W    = 31,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [Q_W-1:0]    quo_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned EW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [Q_W:0]      vld_q;
  logic [EW-1:0]     rem_q  [Q_W+1];
  logic [DEN_W-1:0]  den_q  [Q_W+1];
  logic [Q_W-1:0]    quo_q  [Q_W+1];
  logic [SIDE_W-1:0] side_q [Q_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= EW'(num_i);
      den_q[0]  <= den_i;
      quo_q[0]  <= '0;
      side_q[0] <= side_i;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int unsigned Bit = Q_W - 1 - k;
    logic [EW-1:0] sub;
    logic          ge;

    assign sub = EW'(den_q[k]) << Bit;
    assign ge  = rem_q[k] >= sub;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= ge ? rem_q[k] - sub : rem_q[k];
        den_q[k+1]  <= den_q[k];
        quo_q[k+1]  <= quo_q[k] | (ge ? (Q_W'(1) << Bit) : '0);
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = vld_q[Q_W];
  assign quo_o   = quo_q[Q_W];
  assign side_o  = side_q[Q_W];

endmodule

/* rtl/core/cscr_sqrt_pipe.sv */
module cscr_sqrt_pipe #(
  parameter int unsigned ROOT_W = 31,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [2*ROOT_W-1:0] rad_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output logic [ROOT_W-1:0]   root_o,
  output logic [SIDE_W-1:0]   side_o
);

  localparam int unsigned RW = ROOT_W + 3;

  logic [ROOT_W:0]       vld_q;
  logic [2*ROOT_W-1:0]   rad_q  [ROOT_W+1];
  logic [RW-1:0]         rem_q  [ROOT_W+1];
  logic [ROOT_W-1:0]     root_q [ROOT_W+1];
  logic [SIDE_W-1:0]     side_q [ROOT_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q[0]  <= rad_i;
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      side_q[0] <= side_i;
    end
  end

  // digit by digit: bring down two radicand bits, try root*4+1
  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int unsigned Pair = ROOT_W - 1 - k;
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    logic          ge;

    assign rem_sh = {rem_q[k][RW-3:0], rad_q[k][2*Pair+1 -: 2]};
    assign trial  = RW'({root_q[k], 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k+1]  <= rad_q[k];
        rem_q[k+1]  <= ge ? rem_sh - trial : rem_sh;
        root_q[k+1] <= {root_q[k][ROOT_W-2:0], ge};
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = vld_q[ROOT_W];
  assign root_o  = root_q[ROOT_W];
  assign side_o  = side_q[ROOT_W];

endmodule

/* rtl/core/cscr_resp.sv */
module cscr_resp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  cscr_pkg::norm_t   norm_i,
  output logic              valid_o,
  output cscr_pkg::result_t result_o
);

  // stage 1: products with the normal
  logic                r1_v_q;
  cscr_pkg::norm_t     r1_q;
  logic signed [63:0]  r1_pvx_q, r1_pvy_q, r1_ox_q, r1_oy_q;
  logic signed [31:0]  ov;

  // stage 2: v.n and push-out
  logic                r2_v_q;
  cscr_pkg::norm_t     r2_q;
  logic signed [33:0]  r2_s_q;
  logic signed [31:0]  r2_new_x_q, r2_new_y_q;
  logic signed [65:0]  dot_sum;
  logic signed [31:0]  push_x, push_y;

  // stage 3: s * n
  logic                r3_v_q;
  cscr_pkg::norm_t     r3_q;
  logic signed [31:0]  r3_new_x_q, r3_new_y_q;
  logic signed [65:0]  r3_sx_q, r3_sy_q;

  // stage 4: reflected velocity
  logic                r4_v_q;
  cscr_pkg::result_t   r4_q;
  logic signed [31:0]  vel_x, vel_y;

  assign ov = $signed({1'b0, norm_i.ball.r}) - $signed({1'b0, norm_i.dlen});

  assign dot_sum = 66'(r1_pvx_q) + 66'(r1_pvy_q);
  assign push_x  = cscr_pkg::sat32(66'(r1_q.ball.x)
                   + cscr_pkg::rnd_shift(66'(r1_ox_q), cscr_pkg::NBits));
  assign push_y  = cscr_pkg::sat32(66'(r1_q.ball.y)
                   + cscr_pkg::rnd_shift(66'(r1_oy_q), cscr_pkg::NBits));

  assign vel_x = cscr_pkg::sat32(66'(r3_q.ball.vx)
                 - cscr_pkg::rnd_shift(r3_sx_q, cscr_pkg::NBits - 1));
  assign vel_y = cscr_pkg::sat32(66'(r3_q.ball.vy)
                 - cscr_pkg::rnd_shift(r3_sy_q, cscr_pkg::NBits - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_v_q <= 1'b0;
      r2_v_q <= 1'b0;
      r3_v_q <= 1'b0;
      r4_v_q <= 1'b0;
    end else if (en_i) begin
      r1_v_q <= valid_i;
      r2_v_q <= r1_v_q;
      r3_v_q <= r2_v_q;
      r4_v_q <= r3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r1_q     <= norm_i;
      r1_pvx_q <= norm_i.ball.vx * norm_i.nx;
      r1_pvy_q <= norm_i.ball.vy * norm_i.ny;
      r1_ox_q  <= norm_i.nx * ov;
      r1_oy_q  <= norm_i.ny * ov;

      r2_q       <= r1_q;
      r2_s_q     <= 34'(cscr_pkg::rnd_shift(dot_sum, cscr_pkg::NBits));
      r2_new_x_q <= r1_q.hit ? push_x : r1_q.ball.x;
      r2_new_y_q <= r1_q.hit ? push_y : r1_q.ball.y;

      r3_q       <= r2_q;
      r3_new_x_q <= r2_new_x_q;
      r3_new_y_q <= r2_new_y_q;
      r3_sx_q    <= r2_s_q * r2_q.nx;
      r3_sy_q    <= r2_s_q * r2_q.ny;

      r4_q.hit       <= r3_q.hit;
      r4_q.new_x     <= r3_new_x_q;
      r4_q.new_y     <= r3_new_y_q;
      r4_q.new_vel_x <= r3_q.hit ? vel_x : r3_q.ball.vx;
      r4_q.new_vel_y <= r3_q.hit ? vel_y : r3_q.ball.vy;
    end
  end

  assign valid_o  = r4_v_q;
  assign result_o = r4_q;

endmodule

/* rtl/core/circle_segment_collide_reflect_unit.sv */
// Throughput: one item per cycle while the output buffer is not full; the chain is
// a 32-step divider, a 31-step square root and two 31-step dividers, all fully
// pipelined, with a two-entry output buffer.
// The whole pipeline holds while the output buffer is full; ball_i.ready shows that.
// Reset: asynchronous, active low; clears valid bits and sets the wall registers to zero.
// Configuration writes take effect at once; the config channel is always ready.
module circle_segment_collide_reflect_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cscr_cfg_if.sink   cfg_i,
  cscr_in_if.sink    ball_i,
  cscr_out_if.source result_o
);

  localparam logic [66:0] DegLim =
    67'(((64'd1 << (2 * FRAC_BITS)) - 64'd1) / 64'd10000);
  localparam logic [cscr_pkg::RootW-1:0] NearLim =
    cscr_pkg::RootW'(((64'd1 << FRAC_BITS) - 64'd1) / 64'd10000);

  logic pipe_en;

  // wall registers
  logic signed [31:0] wall_sx_q, wall_sy_q, wall_ex_q, wall_ey_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wall_sx_q <= '0;
      wall_sy_q <= '0;
      wall_ex_q <= '0;
      wall_ey_q <= '0;
    end else if (cfg_i.valid) begin
      case (cscr_pkg::cfg_reg_e'(cfg_i.index))
        cscr_pkg::REG_START_X: wall_sx_q <= cfg_i.data;
        cscr_pkg::REG_START_Y: wall_sy_q <= cfg_i.data;
        cscr_pkg::REG_END_X:   wall_ex_q <= cfg_i.data;
        cscr_pkg::REG_END_Y:   wall_ey_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // ---------------- stage 1: differences
  logic                s1_v_q;
  cscr_pkg::ball_t     s1_ball_q;
  logic signed [31:0]  s1_x1_q, s1_y1_q;
  logic signed [32:0]  s1_wx_q, s1_wy_q, s1_px_q, s1_py_q;

  // ---------------- stage 2: squares and dot products
  logic                s2_v_q;
  cscr_pkg::ball_t     s2_ball_q;
  logic signed [31:0]  s2_x1_q, s2_y1_q;
  logic signed [32:0]  s2_wx_q, s2_wy_q;
  logic signed [65:0]  s2_wwx_q, s2_wwy_q, s2_pwx_q, s2_pwy_q;

  logic signed [66:0]  len, dot;
  logic                t_zero, t_one;
  cscr_pkg::tside_t    td_side_in, td_side_out;
  logic [97:0]         td_num;
  logic                td_v;
  logic [cscr_pkg::TBits-1:0] td_quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else if (pipe_en) begin
      s1_v_q <= ball_i.valid;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s1_ball_q.x  <= ball_i.ball_x;
      s1_ball_q.y  <= ball_i.ball_y;
      s1_ball_q.r  <= ball_i.ball_radius;
      s1_ball_q.vx <= ball_i.ball_vel_x;
      s1_ball_q.vy <= ball_i.ball_vel_y;
      s1_x1_q      <= wall_sx_q;
      s1_y1_q      <= wall_sy_q;
      s1_wx_q      <= 33'(wall_ex_q) - 33'(wall_sx_q);
      s1_wy_q      <= 33'(wall_ey_q) - 33'(wall_sy_q);
      s1_px_q      <= 33'(ball_i.ball_x) - 33'(wall_sx_q);
      s1_py_q      <= 33'(ball_i.ball_y) - 33'(wall_sy_q);

      s2_ball_q <= s1_ball_q;
      s2_x1_q   <= s1_x1_q;
      s2_y1_q   <= s1_y1_q;
      s2_wx_q   <= s1_wx_q;
      s2_wy_q   <= s1_wy_q;
      s2_wwx_q  <= s1_wx_q * s1_wx_q;
      s2_wwy_q  <= s1_wy_q * s1_wy_q;
      s2_pwx_q  <= s1_px_q * s1_wx_q;
      s2_pwy_q  <= s1_py_q * s1_wy_q;
    end
  end

  // clamp cases of the projection parameter; only the open interval divides
  assign len    = 67'(s2_wwx_q) + 67'(s2_wwy_q);
  assign dot    = 67'(s2_pwx_q) + 67'(s2_pwy_q);
  assign t_zero = dot <= 67'sd0;
  assign t_one  = !t_zero && (dot >= len);
  assign td_num = (!t_zero && !t_one) ? {dot[65:0], 32'b0} : '0;

  assign td_side_in.ball   = s2_ball_q;
  assign td_side_in.x1     = s2_x1_q;
  assign td_side_in.y1     = s2_y1_q;
  assign td_side_in.wx     = s2_wx_q;
  assign td_side_in.wy     = s2_wy_q;
  assign td_side_in.degen  = $unsigned(len) <= DegLim;
  assign td_side_in.t_zero = t_zero;
  assign td_side_in.t_one  = t_one;

  cscr_div_pipe #(
    .NUM_W (98),
    .DEN_W (66),
    .Q_W   (cscr_pkg::TBits),
    .SIDE_W($bits(cscr_pkg::tside_t))
  ) u_tdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .valid_i(s2_v_q),
    .num_i  (td_num),
    .den_i  (len[65:0]),
    .side_i (td_side_in),
    .valid_o(td_v),
    .quo_o  (td_quo),
    .side_o (td_side_out)
  );

  // ---------------- closest point
  logic                t1_v_q;
  cscr_pkg::tside_t    t1_q;
  logic [64:0]         t1_prx_q, t1_pry_q;
  logic [cscr_pkg::TBits-1:0] t_frac;
  logic [32:0]         mag_wx, mag_wy;

  logic                t2_v_q;
  cscr_pkg::sside_t    t2_q;
  logic [32:0]         rnd_x, rnd_y;
  logic signed [33:0]  tw_x, tw_y, cx, cy;

  logic                t3_v_q;
  cscr_pkg::sside_t    t3_q;
  logic signed [67:0]  t3_dxx_q, t3_dyy_q;
  logic [61:0]         t3_rr_q;

  logic [68:0]         dsq;
  cscr_pkg::sside_t    sq_side_in, sq_side_out;
  logic                sq_v;
  logic [cscr_pkg::RootW-1:0] sq_root;

  assign t_frac = td_side_out.t_zero ? '0 : td_quo;
  assign mag_wx = td_side_out.wx[32] ? 33'(-td_side_out.wx) : 33'(td_side_out.wx);
  assign mag_wy = td_side_out.wy[32] ? 33'(-td_side_out.wy) : 33'(td_side_out.wy);

  assign rnd_x = 33'((t1_prx_q + (65'd1 << (cscr_pkg::TBits - 1))) >> cscr_pkg::TBits);
  assign rnd_y = 33'((t1_pry_q + (65'd1 << (cscr_pkg::TBits - 1))) >> cscr_pkg::TBits);
  assign tw_x  = t1_q.t_one ? 34'(t1_q.wx)
               : (t1_q.wx[32] ? -$signed({1'b0, rnd_x}) : $signed({1'b0, rnd_x}));
  assign tw_y  = t1_q.t_one ? 34'(t1_q.wy)
               : (t1_q.wy[32] ? -$signed({1'b0, rnd_y}) : $signed({1'b0, rnd_y}));
  assign cx    = 34'(t1_q.x1) + tw_x;
  assign cy    = 34'(t1_q.y1) + tw_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_v_q <= 1'b0;
      t2_v_q <= 1'b0;
      t3_v_q <= 1'b0;
    end else if (pipe_en) begin
      t1_v_q <= td_v;
      t2_v_q <= t1_v_q;
      t3_v_q <= t2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      t1_q     <= td_side_out;
      t1_prx_q <= 65'(t_frac) * 65'(mag_wx);
      t1_pry_q <= 65'(t_frac) * 65'(mag_wy);

      t2_q.ball <= t1_q.ball;
      t2_q.dx   <= 34'(t1_q.ball.x) - cx;
      t2_q.dy   <= 34'(t1_q.ball.y) - cy;
      t2_q.hit  <= !t1_q.degen;

      t3_q     <= t2_q;
      t3_dxx_q <= t2_q.dx * t2_q.dx;
      t3_dyy_q <= t2_q.dy * t2_q.dy;
      t3_rr_q  <= 62'(t2_q.ball.r) * 62'(t2_q.ball.r);
    end
  end

  assign dsq = 69'(t3_dxx_q) + 69'(t3_dyy_q);

  assign sq_side_in.ball = t3_q.ball;
  assign sq_side_in.dx   = t3_q.dx;
  assign sq_side_in.dy   = t3_q.dy;
  assign sq_side_in.hit  = t3_q.hit && (dsq <= 69'(t3_rr_q));

  cscr_sqrt_pipe #(
    .ROOT_W(cscr_pkg::RootW),
    .SIDE_W($bits(cscr_pkg::sside_t))
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .valid_i(t3_v_q),
    .rad_i  (dsq[2*cscr_pkg::RootW-1:0]),
    .side_i (sq_side_in),
    .valid_o(sq_v),
    .root_o (sq_root),
    .side_o (sq_side_out)
  );

  // ---------------- normal
  logic                d1_v_q;
  cscr_pkg::sside_t    d1_q;
  logic [cscr_pkg::RootW-1:0] d1_dist_q;

  logic [33:0]         mag_dx, mag_dy;
  logic [65:0]         nn_x, nn_y, nd_lim;
  logic [31:0]         nden;
  logic                dzero, ovf_x, ovf_y;
  cscr_pkg::nside_t    nx_side_in, nx_side_out;
  logic                ny_ovf_out;
  logic                nxd_v, nyd_v;
  logic [cscr_pkg::RootW-1:0] qx, qy;

  logic                n1_v_q;
  cscr_pkg::norm_t     n1_q;

  function automatic logic signed [31:0] norm_fix(input logic [cscr_pkg::RootW-1:0] q,
                                                  input logic dz, input logic ovf,
                                                  input logic neg);
    logic [cscr_pkg::RootW-1:0] m;
    if (dz) begin
      m = '0;
    end else if (ovf || q > cscr_pkg::NormOne) begin
      m = cscr_pkg::NormOne;
    end else begin
      m = q;
    end
    return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      d1_q      <= sq_side_out;
      d1_dist_q <= (sq_root <= NearLim) ? sq_side_out.ball.r : sq_root;
    end
  end

  assign mag_dx = d1_q.dx[33] ? 34'(-d1_q.dx) : 34'(d1_q.dx);
  assign mag_dy = d1_q.dy[33] ? 34'(-d1_q.dy) : 34'(d1_q.dy);
  assign nn_x   = (66'(mag_dx) << (cscr_pkg::NBits + 1)) + 66'(d1_dist_q);
  assign nn_y   = (66'(mag_dy) << (cscr_pkg::NBits + 1)) + 66'(d1_dist_q);
  assign nden   = {d1_dist_q, 1'b0};
  assign nd_lim = 66'(nden) << cscr_pkg::RootW;
  assign dzero  = d1_dist_q == '0;
  assign ovf_x  = nn_x >= nd_lim;
  assign ovf_y  = nn_y >= nd_lim;

  assign nx_side_in.ball   = d1_q.ball;
  assign nx_side_in.dlen   = d1_dist_q;
  assign nx_side_in.dx_neg = d1_q.dx[33];
  assign nx_side_in.dy_neg = d1_q.dy[33];
  assign nx_side_in.dzero  = dzero;
  assign nx_side_in.ovf    = ovf_x;
  assign nx_side_in.hit    = d1_q.hit;

  cscr_div_pipe #(
    .NUM_W (66),
    .DEN_W (32),
    .Q_W   (cscr_pkg::RootW),
    .SIDE_W($bits(cscr_pkg::nside_t))
  ) u_ndiv_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .valid_i(d1_v_q),
    .num_i  ((dzero || ovf_x) ? 66'd0 : nn_x),
    .den_i  (nden),
    .side_i (nx_side_in),
    .valid_o(nxd_v),
    .quo_o  (qx),
    .side_o (nx_side_out)
  );

  cscr_div_pipe #(
    .NUM_W (66),
    .DEN_W (32),
    .Q_W   (cscr_pkg::RootW),
    .SIDE_W(1)
  ) u_ndiv_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .valid_i(d1_v_q),
    .num_i  ((dzero || ovf_y) ? 66'd0 : nn_y),
    .den_i  (nden),
    .side_i (ovf_y),
    .valid_o(nyd_v),
    .quo_o  (qy),
    .side_o (ny_ovf_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_v_q <= 1'b0;
      n1_v_q <= 1'b0;
    end else if (pipe_en) begin
      d1_v_q <= sq_v;
      n1_v_q <= nxd_v && nyd_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      n1_q.ball <= nx_side_out.ball;
      n1_q.dlen <= nx_side_out.dlen;
      n1_q.hit  <= nx_side_out.hit;
      n1_q.nx   <= norm_fix(qx, nx_side_out.dzero, nx_side_out.ovf, nx_side_out.dx_neg);
      n1_q.ny   <= norm_fix(qy, nx_side_out.dzero, ny_ovf_out, nx_side_out.dy_neg);
    end
  end

  // ---------------- response
  logic              rs_v;
  cscr_pkg::result_t rs_res;

  cscr_resp u_resp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (n1_v_q),
    .norm_i  (n1_q),
    .valid_o (rs_v),
    .result_o(rs_res)
  );

  // ---------------- output buffer: head register plus one skid entry
  logic              out_v_q, skid_v_q;
  cscr_pkg::result_t out_q, skid_q;
  logic              push, pop;

  assign pipe_en      = !skid_v_q;
  assign ball_i.ready = pipe_en;
  assign push         = pipe_en && rs_v;
  assign pop          = out_v_q && result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q) begin
      out_v_q <= push;
    end else if (pop) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= push;
      end
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || pop) begin
      out_q <= skid_v_q ? skid_q : rs_res;
    end
    if (out_v_q && !pop && push) begin
      skid_q <= rs_res;
    end
  end

  assign result_o.valid     = out_v_q;
  assign result_o.hit       = out_q.hit;
  assign result_o.new_x     = out_q.new_x;
  assign result_o.new_y     = out_q.new_y;
  assign result_o.new_vel_x = out_q.new_vel_x;
  assign result_o.new_vel_y = out_q.new_vel_y;

endmodule

/* rtl/core/cscr_checker.sv */
module cscr_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         in_valid_i,
  input logic         in_ready_i,
  input logic         out_valid_i,
  input logic         out_ready_i,
  input logic [128:0] out_data_i
);

  logic [7:0] cnt_q, cnt_d;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;
  assign cnt_d   = cnt_q + 8'(in_acc) - 8'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // a result needs an item still in flight
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> cnt_q != 8'd0)
    else $error("result delivered with no item outstanding");

  // input holds off only while at least two items are outstanding
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> cnt_q >= 8'd2)
    else $error("input stalled with fewer than two items outstanding");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result valid dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> $stable(out_data_i))
    else $error("result changed while stalled");

endmodule

bind circle_segment_collide_reflect_unit cscr_checker u_cscr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (ball_i.valid),
  .in_ready_i (ball_i.ready),
  .out_valid_i(result_o.valid),
  .out_ready_i(result_o.ready),
  .out_data_i ({result_o.hit, result_o.new_x, result_o.new_y,
                result_o.new_vel_x, result_o.new_vel_y})
);
